[rtl/srde_pkg.sv]
`timescale 1ns / 1ps
// shared constants, command and status types and the reciprocal table of the digit emitter
package srde_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int MAX_SYMBOLS  = 16;
    localparam int SYM_W        = 8;
    localparam int COUNT_W      = 5;
    localparam int DIGIT_W      = 4;
    localparam int MAX_DIGITS   = 32;
    localparam int DIGIT_IDX_W  = 5;
    localparam int DCOUNT_W     = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int PROD_W       = 2 * NUMBER_WIDTH;
    localparam int REM_W        = 6;

    // character codes
    localparam logic [SYM_W-1:0] MINUS_CHAR  = 8'd45;
    localparam logic [SYM_W-1:0] PLUS_CHAR   = 8'd43;
    localparam logic [SYM_W-1:0] LOWEST_BAD  = 8'd32;
    localparam logic [SYM_W-1:0] HIGHEST_BAD = 8'd126;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HI   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic div;
        logic out_load;
        logic out_minus;
    } srde_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic q_zero;
        logic last_digit;
        logic out_free;
    } srde_status_t;

    // floor(2^32 / n), used as an underestimating reciprocal of the radix
    function automatic logic [NUMBER_WIDTH-1:0] recip_of(input logic [COUNT_W-1:0] n);
        logic [NUMBER_WIDTH-1:0] r;
        unique case (n)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/srde_datapath.sv]
`timescale 1ns / 1ps
// datapath: config registers, alphabet check, divide-by-radix unit, digit store, output register
module srde_datapath
    import srde_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic [NUMBER_WIDTH-1:0] s_tdata,
    input  srde_cmd_t               cmd,
    output srde_status_t            status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SYM_W-1:0]        m_tdata,
    output logic                    m_tlast
);

    logic [COUNT_W-1:0]      count_reg;
    logic [CFG_DATA_W-1:0]   sym_lo_reg;
    logic [CFG_DATA_W-1:0]   sym_hi_reg;
    logic [COUNT_W-1:0]      eff_n;
    logic [2*CFG_DATA_W-1:0] sym_all;
    logic [SYM_W-1:0]        sym [MAX_SYMBOLS];
    logic                    alpha_ok;

    logic [NUMBER_WIDTH-1:0] mag_reg;
    logic [NUMBER_WIDTH-1:0] mag_next;
    logic                    neg_reg;
    logic [NUMBER_WIDTH-1:0] recip_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [DCOUNT_W-1:0]     ndig_reg;
    logic [DCOUNT_W-1:0]     nd_m1;
    logic [DIGIT_W-1:0]      digits [MAX_DIGITS];

    logic [NUMBER_WIDTH-1:0]         q_est;
    logic [NUMBER_WIDTH+COUNT_W-1:0] qn;
    logic [NUMBER_WIDTH-1:0]         diff;
    logic [REM_W-1:0]                r_est;
    logic [REM_W-1:0]                r_fix;
    logic                            corr;
    logic [NUMBER_WIDTH-1:0]         q_fix;
    logic [DIGIT_IDX_W-1:0]          rd_idx;

    logic             m_tvalid_reg;
    logic [SYM_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SYMBOL_COUNT: count_reg  <= cfg_data[COUNT_W-1:0];
                REG_SYMBOLS_LO:   sym_lo_reg <= cfg_data;
                REG_SYMBOLS_HI:   sym_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // radix saturates at the alphabet cap
    assign eff_n   = (count_reg > COUNT_W'(MAX_SYMBOLS)) ? COUNT_W'(MAX_SYMBOLS) : count_reg;
    assign sym_all = {sym_hi_reg, sym_lo_reg};

    always_comb begin
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            sym[i] = sym_all[i*SYM_W +: SYM_W];
        end
    end

    // alphabet check: range, sign chars, and every pair in use
    always_comb begin
        alpha_ok = (eff_n >= COUNT_W'(2));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (COUNT_W'(i) < eff_n) begin
                if (sym[i] == PLUS_CHAR || sym[i] == MINUS_CHAR ||
                    sym[i] <= LOWEST_BAD || sym[i] >= HIGHEST_BAD) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (COUNT_W'(j) < eff_n && sym[j] == sym[i]) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // magnitude of the input; the most negative value maps onto the sign bit
    assign mag_next = s_tdata[NUMBER_WIDTH-1] ? (~s_tdata + NUMBER_WIDTH'(1)) : s_tdata;

    // quotient estimate with one correction step
    assign q_est = prod_reg[PROD_W-1:NUMBER_WIDTH];
    assign qn    = {{COUNT_W{1'b0}}, q_est} * {{NUMBER_WIDTH{1'b0}}, eff_n};
    assign diff  = mag_reg - qn[NUMBER_WIDTH-1:0];
    assign r_est = diff[REM_W-1:0];
    assign corr  = (r_est >= {1'b0, eff_n});
    assign q_fix = q_est + {{(NUMBER_WIDTH-1){1'b0}}, corr};
    assign r_fix = corr ? (r_est - {1'b0, eff_n}) : r_est;

    assign nd_m1  = ndig_reg - DCOUNT_W'(1);
    assign rd_idx = nd_m1[DIGIT_IDX_W-1:0];

    // digit count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ndig_reg <= '0;
        end else if (cmd.load_in) begin
            ndig_reg <= '0;
        end else if (cmd.div) begin
            ndig_reg <= ndig_reg + DCOUNT_W'(1);
        end else if (cmd.out_load && !cmd.out_minus) begin
            ndig_reg <= nd_m1;
        end
    end

    // number, reciprocal, product and digit store
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mag_reg   <= mag_next;
            neg_reg   <= s_tdata[NUMBER_WIDTH-1];
            recip_reg <= recip_of(eff_n);
        end else if (cmd.div) begin
            mag_reg <= q_fix;
        end
        if (cmd.mul) begin
            prod_reg <= mag_reg * recip_reg;
        end
        if (cmd.div) begin
            digits[ndig_reg[DIGIT_IDX_W-1:0]] <= r_fix[DIGIT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= cmd.out_minus ? MINUS_CHAR : sym[digits[rd_idx]];
            m_tlast_reg <= !cmd.out_minus && (ndig_reg == DCOUNT_W'(1));
        end
    end

    assign status.alpha_ok   = alpha_ok;
    assign status.neg        = neg_reg;
    assign status.q_zero     = (q_fix == '0);
    assign status.last_digit = (ndig_reg == DCOUNT_W'(1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/srde_ctrl.sv]
`timescale 1ns / 1ps
// controller: sequences check, digit extraction and character output
module srde_ctrl
    import srde_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  srde_status_t status,
    output srde_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SIGN  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.alpha_ok ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (status.q_zero) begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_minus = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/signed_radix_digit_emitter_core.sv]
`timescale 1ns / 1ps
// top level of the signed radix digit emitter
// an input number is loaded and the alphabet checked, then each of its digits (1 to 32) takes a multiply
// step and a divide-and-correct step; a minus sign goes out first for a negative number, then the digits,
// each character waiting until the output register is free; a new number is taken only after the last
// character has been loaded into the output register; an invalid alphabet drops a number after the check
// reset (synchronous, active low) clears config to zero; the last character may wait in the output register while the next number is taken
module signed_radix_digit_emitter_core
    import srde_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [NUMBER_WIDTH-1:0] s_tdata,   // [31:0] number
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SYM_W-1:0]        m_tdata,   // [7:0] symbol
    output logic                    m_tlast
);

    srde_cmd_t    cmd;
    srde_status_t status;

    srde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srde_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[rtl/srde_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the digit emitter, bound to the top level
module srde_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled output beat stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // a number accepted means the block is busy next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // while idle only the final character of the previous text may wait
    a_idle_pending_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with a non-final character pending");

    // a stalled output beat keeps its character and last flag
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

endmodule

bind signed_radix_digit_emitter_core srde_checker u_srde_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the signed radix digit emitter core
module tb_top;
    import srde_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 42;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // decimal and hex alphabets, symbol 0 in the lowest byte
    localparam logic [63:0] DIGITS_0_TO_7 = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DIGITS_8_9 = 64'hFFFF_2B2D_2020_3938;
    localparam logic [63:0] DIGITS_8_TO_F = 64'h4645_4443_4241_3938;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } char_beat_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [NUMBER_WIDTH-1:0] s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [SYM_W-1:0]        m_tdata;
    logic                    m_tlast;

    // shadow copy of the configuration registers
    logic [COUNT_W-1:0] shadow_count = '0;
    logic [63:0]        shadow_lo = '0;
    logic [63:0]        shadow_hi = '0;

    logic [NUMBER_WIDTH-1:0] number_q[$];
    char_beat_t              text_q[$];
    int                      numbers_sent = 0;
    int                      numbers_taken = 0;
    int                      cycle_cnt = 0;
    logic                    number_beat = 1'b0;
    bit                      failed = 1'b0;
    logic                    quiet;

    signed_radix_digit_emitter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // no idling while bits 13:12 of the cycle count are both set
    assign quiet = (cycle_cnt[13:12] == 2'b11);

    function automatic int radix_in_use();
        return (shadow_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(shadow_count);
    endfunction

    function automatic logic [SYM_W-1:0] alphabet_symbol(int idx);
        return (idx < 8) ? shadow_lo[idx*8 +: 8] : shadow_hi[(idx-8)*8 +: 8];
    endfunction

    function automatic bit alphabet_usable(int n);
        logic [SYM_W-1:0] c;
        if (n < 2) return 1'b0;
        for (int i = 0; i < n; i++) begin
            c = alphabet_symbol(i);
            if (c == PLUS_CHAR || c == MINUS_CHAR) return 1'b0;
            if (c <= LOWEST_BAD || c >= HIGHEST_BAD) return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (alphabet_symbol(j) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected characters of one number's text, most significant digit first
    function automatic void predict_text(logic [NUMBER_WIDTH-1:0] num);
        int               n;
        logic [31:0]      radix;
        logic [31:0]      mag;
        logic [3:0]       digs[MAX_DIGITS+1];
        int               nd;
        char_beat_t       beat;
        n = radix_in_use();
        if (!alphabet_usable(n)) return;
        radix = n;
        // most negative value negates to itself, which is the right magnitude
        mag = num[NUMBER_WIDTH-1] ? -num : num;
        nd = 0;
        do begin
            digs[nd] = 4'(mag % radix);
            mag = mag / radix;
            nd++;
        end while (mag != 0);
        if (num[NUMBER_WIDTH-1]) begin
            beat.symbol = MINUS_CHAR;
            beat.last = 1'b0;
            text_q.push_back(beat);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            beat.symbol = alphabet_symbol(int'(digs[k]));
            beat.last = (k == 0);
            text_q.push_back(beat);
        end
    endfunction

    // input driver, new beats launched on the falling edge
    always @(negedge aclk) begin
        if (!s_tvalid || number_beat) begin
            if (number_q.size() != 0 && (quiet || $urandom_range(99) >= 26)) begin
                s_tvalid <= 1'b1;
                s_tdata <= number_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 26);
    end

    // monitor: check output beats, predict on accepted input beats
    always @(posedge aclk) begin
        char_beat_t want;
        if (m_tvalid && m_tready) begin
            if (text_q.size() == 0) begin
                $error("unexpected character: symbol %h last %b", m_tdata, m_tlast);
                failed = 1'b1;
            end else begin
                want = text_q.pop_front();
                if (m_tdata !== want.symbol) begin
                    $error("symbol mismatch: expected %h actual %h", want.symbol, m_tdata);
                    failed = 1'b1;
                end
                if (m_tlast !== want.last) begin
                    $error("last mismatch: expected %b actual %b", want.last, m_tlast);
                    failed = 1'b1;
                end
            end
        end
        if (s_tvalid && s_tready) begin
            predict_text(s_tdata);
            numbers_taken++;
        end
        number_beat <= s_tvalid && s_tready;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL signed_radix_digit_emitter_core");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_SYMBOL_COUNT: shadow_count = value[COUNT_W-1:0];
            REG_SYMBOLS_LO:   shadow_lo = value;
            REG_SYMBOLS_HI:   shadow_hi = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // count value with random bits above the field
    task automatic set_alphabet(input logic [COUNT_W-1:0] cnt, input logic [63:0] lo,
                                input logic [63:0] hi);
        logic [63:0] cnt_word;
        cnt_word = {$urandom, $urandom};
        cnt_word[COUNT_W-1:0] = cnt;
        write_reg(REG_SYMBOL_COUNT, cnt_word);
        write_reg(REG_SYMBOLS_LO, lo);
        write_reg(REG_SYMBOLS_HI, hi);
    endtask

    task automatic send_number(input logic [NUMBER_WIDTH-1:0] num);
        number_q.push_back(num);
        numbers_sent++;
    endtask

    // all numbers taken, all text seen, then let a dropped number finish
    task automatic wait_idle();
        do @(negedge aclk);
        while (numbers_taken != numbers_sent || text_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // random alphabet of n distinct legal symbols, optionally broken in one place
    task automatic random_alphabet(input int n, input bit broken);
        logic [SYM_W-1:0] syms[MAX_SYMBOLS];
        logic [SYM_W-1:0] c;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [COUNT_W-1:0] cnt;
        bit               clash;
        int               k;
        int               j;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        for (k = 0; k < n; k++) begin
            do begin
                c = SYM_W'($urandom_range(33, 125));
                clash = (c == PLUS_CHAR || c == MINUS_CHAR);
                for (j = 0; j < k; j++)
                    if (syms[j] == c) clash = 1'b1;
            end while (clash);
            syms[k] = c;
        end
        if (broken) begin
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
                0: syms[k] = PLUS_CHAR;
                1: syms[k] = MINUS_CHAR;
                2: syms[k] = SYM_W'($urandom_range(0, 32));
                3: syms[k] = SYM_W'($urandom_range(126, 255));
                4: syms[k] = $urandom_range(0, 1) ? LOWEST_BAD : HIGHEST_BAD;
                default: begin
                    j = (k + $urandom_range(1, n - 1)) % n;
                    syms[k] = syms[j];
                end
            endcase
        end
        for (k = 0; k < n; k++) begin
            if (k < 8) lo[k*8 +: 8] = syms[k];
            else hi[(k-8)*8 +: 8] = syms[k];
        end
        cnt = COUNT_W'(n);
        if (n == MAX_SYMBOLS && $urandom_range(0, 1)) cnt = COUNT_W'($urandom_range(17, 31));
        set_alphabet(cnt, lo, hi);
        // stray write to the unused index now and then
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    function automatic logic [NUMBER_WIDTH-1:0] random_number(int radix);
        logic [63:0]             p;
        logic [NUMBER_WIDTH-1:0] v;
        int                      k;
        if (radix < 2) radix = 10;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: begin
                v = $urandom_range(0, 40);
                if ($urandom_range(0, 1)) v = -v;
            end
            2: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: begin
                // around a power of the radix, where the digit count steps
                p = 64'd1;
                k = $urandom_range(1, 31);
                while (k > 0 && p * radix <= 64'h7FFF_FFFF) begin
                    p = p * radix;
                    k--;
                end
                v = p[31:0] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // stimulus
    initial begin
        int n;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset config has zero symbols: nothing comes out
        send_number(32'd0);
        send_number(32'hFFFF_FFFF);
        wait_idle();

        // a single symbol is not an alphabet
        set_alphabet(5'd1, DIGITS_0_TO_7, DIGITS_8_9);
        send_number(32'd5);
        wait_idle();

        // decimal, junk in unused bytes
        set_alphabet(5'd10, DIGITS_0_TO_7, DIGITS_8_9);
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd9);
        send_number(32'd10);
        send_number(-32'sd10);
        wait_idle();

        // binary with the lowest and highest legal symbols, longest text
        set_alphabet(5'd2, 64'h2121_2B2D_8000_7D21, 64'h2121_2121_2121_2121);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'hFFFF_FFFF);
        send_number(32'd0);
        send_number(32'd5);
        wait_idle();

        // hex via a count above the cap, write to the unused index has no effect
        set_alphabet(5'd31, DIGITS_0_TO_7, DIGITS_8_TO_F);
        write_reg(REG_UNUSED, 64'h2B2B_2B2B_2B2B_2B2B);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'hDEAD_BEEF);
        wait_idle();

        // broken alphabets: plus, minus, space, tilde, high byte, far duplicate
        set_alphabet(5'd10, 64'h3736_3534_2B32_3130, DIGITS_8_9);
        send_number(-32'sd12345);
        wait_idle();
        set_alphabet(5'd10, DIGITS_0_TO_7, 64'h0000_0000_0000_2D38);
        send_number(32'd12345);
        wait_idle();
        set_alphabet(5'd10, 64'h3736_3534_3332_3120, DIGITS_8_9);
        send_number(32'd77);
        wait_idle();
        set_alphabet(5'd10, 64'h3736_7E34_3332_3130, DIGITS_8_9);
        send_number(32'd78);
        wait_idle();
        set_alphabet(5'd16, DIGITS_0_TO_7, 64'h4645_44C1_4241_3938);
        send_number(32'd79);
        wait_idle();
        set_alphabet(5'd16, DIGITS_0_TO_7, 64'h4631_4443_4241_3938);
        send_number(32'd80);
        wait_idle();

        // random alphabets, a few of them broken
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: n = 2;
                1: n = MAX_SYMBOLS;
                2: n = 10;
                default: n = $urandom_range(2, MAX_SYMBOLS);
            endcase
            random_alphabet(n, 1'b0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_number(random_number(n));
            wait_idle();
            if (ph % 3 == 1) begin
                random_alphabet($urandom_range(2, MAX_SYMBOLS), 1'b1);
                for (int i = 0; i < 6; i++)
                    send_number(random_number(10));
                wait_idle();
            end
        end

        if (!failed) begin
            $display("PASS signed_radix_digit_emitter_core");
        end else begin
            $display("FAIL signed_radix_digit_emitter_core");
        end
        $finish;
    end

endmodule
